/* sv/quad_vertex_order_fix_macros.svh */
// Assertion macros shared by the quad vertex order fixer modules.
`ifndef QUAD_VERTEX_ORDER_FIX_MACROS_SVH
`define QUAD_VERTEX_ORDER_FIX_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define QVOF_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Condition that must never be true at a clock edge outside reset.
`define QVOF_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

/* sv/qvof_pkg.sv */
// Shared codes, types and corner-order helpers for the quad vertex order fixer.
package qvof_pkg;

  localparam int NUM_CORNERS = 4;
  localparam int QUEUE_DEPTH = 4;

  // Corner indices in input order.
  localparam logic [1:0] CORNER_A = 2'd0;
  localparam logic [1:0] CORNER_B = 2'd1;
  localparam logic [1:0] CORNER_C = 2'd2;
  localparam logic [1:0] CORNER_D = 2'd3;

  // Result status codes.
  localparam logic [1:0] ST_KEPT       = 2'd0;
  localparam logic [1:0] ST_REVERSED   = 2'd1;
  localparam logic [1:0] ST_PERMUTED   = 2'd2;
  localparam logic [1:0] ST_NONE_FOUND = 2'd3;

  // Number of positive turns of a fully consistent winding.
  localparam logic [2:0] ALL_TURNS  = 3'd4;
  localparam logic [2:0] HALF_TURNS = 3'd2;
  localparam logic [2:0] NO_TURNS   = 3'd0;

  // Output corner orders.
  typedef enum logic [2:0] {
    ORD_ABCD,
    ORD_DCBA,
    ORD_ABDC,
    ORD_ACBD,
    ORD_ACDB,
    ORD_ADBC,
    ORD_ADCB
  } ord_sel_t;

  // Decision handed from the classifier to the reorder stage.
  typedef struct packed {
    ord_sel_t   sel;
    logic [1:0] status;
  } order_dec_t;

  // True when the turn through corners i, j, k is strictly positive. The
  // turn of a corner triple only flips sign under an odd permutation, so
  // it is looked up from the sign of the sorted triple that leaves out
  // corner i^j^k.
  function automatic logic turn_pos(input logic [3:0] pos, input logic [3:0] neg,
                                    input logic [1:0] i, input logic [1:0] j,
                                    input logic [1:0] k);
    logic [1:0] m;
    logic       odd;
    m   = i ^ j ^ k;
    odd = (i > j) ^ (i > k) ^ (j > k);
    return odd ? neg[m] : pos[m];
  endfunction

  // Number of positive turns over the four cyclic triples of an order.
  function automatic logic [2:0] turn_count(input logic [3:0] pos, input logic [3:0] neg,
                                            input logic [1:0] o0, input logic [1:0] o1,
                                            input logic [1:0] o2, input logic [1:0] o3);
    return 3'(turn_pos(pos, neg, o0, o1, o2)) + 3'(turn_pos(pos, neg, o1, o2, o3))
         + 3'(turn_pos(pos, neg, o2, o3, o0)) + 3'(turn_pos(pos, neg, o3, o0, o1));
  endfunction

  // Input corner that lands in a given output slot.
  function automatic logic [1:0] order_corner(input ord_sel_t sel, input logic [1:0] slot);
    logic [7:0] ord;
    case (sel)
      ORD_ABCD: ord = {CORNER_D, CORNER_C, CORNER_B, CORNER_A};
      ORD_DCBA: ord = {CORNER_A, CORNER_B, CORNER_C, CORNER_D};
      ORD_ABDC: ord = {CORNER_C, CORNER_D, CORNER_B, CORNER_A};
      ORD_ACBD: ord = {CORNER_D, CORNER_B, CORNER_C, CORNER_A};
      ORD_ACDB: ord = {CORNER_B, CORNER_D, CORNER_C, CORNER_A};
      ORD_ADBC: ord = {CORNER_C, CORNER_B, CORNER_D, CORNER_A};
      ORD_ADCB: ord = {CORNER_B, CORNER_C, CORNER_D, CORNER_A};
      default:  ord = {CORNER_D, CORNER_C, CORNER_B, CORNER_A};
    endcase
    return ord[{slot, 1'b0} +: 2];
  endfunction

endpackage

/* sv/qvof_fifo.sv */
// Short register queue between the classifying front end and the reorder back end.
`include "quad_vertex_order_fix_macros.svh"

module qvof_fifo
  import qvof_pkg::*;
#(
  parameter int WIDTH,
  parameter int DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push_valid,
  output logic             push_ready,
  input  logic [WIDTH-1:0] push_data,
  output logic             pop_valid,
  input  logic             pop_ready,
  output logic [WIDTH-1:0] pop_data
);

  localparam int AW = $clog2(DEPTH);
  localparam logic [AW:0] FULL_COUNT = (AW + 1)'(DEPTH);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [AW:0]      count;
  logic [AW:0]      count_next;
  logic             push_fire;
  logic             pop_fire;

  // Handshake status comes straight from the fill count.
  assign push_ready = (count != FULL_COUNT);
  assign pop_valid  = (count != '0);
  assign pop_data   = mem[rd_ptr];
  assign push_fire  = push_valid && push_ready;
  assign pop_fire   = pop_valid && pop_ready;

  // Fill count follows pushes and pops.
  always_comb begin
    count_next = count;
    if (push_fire && !pop_fire) begin
      count_next = count + 1'b1;
    end else if (pop_fire && !push_fire) begin
      count_next = count - 1'b1;
    end
  end

  // Pointers and count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      count <= count_next;
      if (push_fire) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop_fire) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push_fire) begin
      mem[wr_ptr] <= push_data;
    end
  end

  `QVOF_ASSERT(fifo_count_up, push_fire && !pop_fire |=> count == $past(count) + 1'b1, "queue count did not follow a push")
  `QVOF_ASSERT(fifo_empty_ptrs, count == '0 |-> wr_ptr == rd_ptr, "empty queue with unequal pointers")

endmodule

/* sv/qvof_front.sv */
// Front end: accepts quads, computes the four triple orientations and picks the corner order.
`include "quad_vertex_order_fix_macros.svh"

module qvof_front
  import qvof_pkg::*;
#(
  parameter int COORD_WIDTH
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    in_valid,
  output logic                                    in_ready,
  input  logic signed [COORD_WIDTH-1:0]           a_x,
  input  logic signed [COORD_WIDTH-1:0]           a_y,
  input  logic signed [COORD_WIDTH-1:0]           b_x,
  input  logic signed [COORD_WIDTH-1:0]           b_y,
  input  logic signed [COORD_WIDTH-1:0]           c_x,
  input  logic signed [COORD_WIDTH-1:0]           c_y,
  input  logic signed [COORD_WIDTH-1:0]           d_x,
  input  logic signed [COORD_WIDTH-1:0]           d_y,
  output logic                                    push_valid,
  input  logic                                    push_ready,
  output logic [NUM_CORNERS-1:0][COORD_WIDTH-1:0] push_x,
  output logic [NUM_CORNERS-1:0][COORD_WIDTH-1:0] push_y,
  output order_dec_t                              push_dec
);

  localparam int DIFF_W = COORD_WIDTH + 1;
  localparam int PROD_W = 2 * DIFF_W;

  logic [NUM_CORNERS-1:0][COORD_WIDTH-1:0] in_x;
  logic [NUM_CORNERS-1:0][COORD_WIDTH-1:0] in_y;
  logic signed [DIFF_W-1:0] fx_in [NUM_CORNERS];
  logic signed [DIFF_W-1:0] fy_in [NUM_CORNERS];
  logic signed [DIFF_W-1:0] tx_in [NUM_CORNERS];
  logic signed [DIFF_W-1:0] ty_in [NUM_CORNERS];

  logic                                    adv;
  logic                                    s1_valid;
  logic                                    s2_valid;
  logic                                    s3_valid;
  logic [NUM_CORNERS-1:0][COORD_WIDTH-1:0] s1_x;
  logic [NUM_CORNERS-1:0][COORD_WIDTH-1:0] s1_y;
  logic [NUM_CORNERS-1:0][COORD_WIDTH-1:0] s2_x;
  logic [NUM_CORNERS-1:0][COORD_WIDTH-1:0] s2_y;
  logic [NUM_CORNERS-1:0][COORD_WIDTH-1:0] s3_x;
  logic [NUM_CORNERS-1:0][COORD_WIDTH-1:0] s3_y;
  logic signed [DIFF_W-1:0] s1_fx [NUM_CORNERS];
  logic signed [DIFF_W-1:0] s1_fy [NUM_CORNERS];
  logic signed [DIFF_W-1:0] s1_tx [NUM_CORNERS];
  logic signed [DIFF_W-1:0] s1_ty [NUM_CORNERS];
  logic signed [PROD_W-1:0] s2_p  [NUM_CORNERS];
  logic signed [PROD_W-1:0] s2_q  [NUM_CORNERS];
  logic [NUM_CORNERS-1:0]   s3_pos;
  logic [NUM_CORNERS-1:0]   s3_neg;
  logic [2:0]               n_keep;
  order_dec_t               dec;

  function automatic logic signed [DIFF_W-1:0] sx(input logic [COORD_WIDTH-1:0] v);
    return $signed({v[COORD_WIDTH-1], v});
  endfunction

  assign in_x = {d_x, c_x, b_x, a_x};
  assign in_y = {d_y, c_y, b_y, a_y};

  // Edge vectors of the sorted triple that leaves out corner m.
  for (genvar m = 0; m < NUM_CORNERS; m++) begin : g_tri
    localparam int I = (m == 0) ? 1 : 0;
    localparam int J = (m <= 1) ? 2 : 1;
    localparam int K = (m == 3) ? 2 : 3;
    assign fx_in[m] = sx(in_x[J]) - sx(in_x[I]);
    assign fy_in[m] = sx(in_y[J]) - sx(in_y[I]);
    assign tx_in[m] = sx(in_x[K]) - sx(in_x[J]);
    assign ty_in[m] = sx(in_y[K]) - sx(in_y[J]);
  end

  // The whole pipe moves together unless its last beat waits on the queue.
  assign adv      = !s3_valid || push_ready;
  assign in_ready = adv;

  // Stage valid bits.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
    end else if (adv) begin
      s1_valid <= in_valid;
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
    end
  end

  // Edge vectors, then cross products, then their signs.
  always_ff @(posedge clk) begin
    if (adv) begin
      s1_x  <= in_x;
      s1_y  <= in_y;
      s2_x  <= s1_x;
      s2_y  <= s1_y;
      s3_x  <= s2_x;
      s3_y  <= s2_y;
      s1_fx <= fx_in;
      s1_fy <= fy_in;
      s1_tx <= tx_in;
      s1_ty <= ty_in;
      for (int m = 0; m < NUM_CORNERS; m++) begin
        s2_p[m]   <= s1_fy[m] * s1_tx[m];
        s2_q[m]   <= s1_fx[m] * s1_ty[m];
        s3_pos[m] <= s2_p[m] > s2_q[m];
        s3_neg[m] <= s2_p[m] < s2_q[m];
      end
    end
  end

  // Score the given order; a zero score reverses it and a score of two searches the alternatives.
  assign n_keep = turn_count(s3_pos, s3_neg, CORNER_A, CORNER_B, CORNER_C, CORNER_D);

  always_comb begin
    dec.sel    = ORD_ABCD;
    dec.status = ST_KEPT;
    if (n_keep == NO_TURNS) begin
      dec.sel    = ORD_DCBA;
      dec.status = ST_REVERSED;
    end else if (n_keep == HALF_TURNS) begin
      dec.status = ST_PERMUTED;
      if (turn_count(s3_pos, s3_neg, CORNER_A, CORNER_B, CORNER_D, CORNER_C) == ALL_TURNS) begin
        dec.sel = ORD_ABDC;
      end else if (turn_count(s3_pos, s3_neg, CORNER_A, CORNER_C, CORNER_B, CORNER_D)
                   == ALL_TURNS) begin
        dec.sel = ORD_ACBD;
      end else if (turn_count(s3_pos, s3_neg, CORNER_A, CORNER_C, CORNER_D, CORNER_B)
                   == ALL_TURNS) begin
        dec.sel = ORD_ACDB;
      end else if (turn_count(s3_pos, s3_neg, CORNER_A, CORNER_D, CORNER_B, CORNER_C)
                   == ALL_TURNS) begin
        dec.sel = ORD_ADBC;
      end else if (turn_count(s3_pos, s3_neg, CORNER_A, CORNER_D, CORNER_C, CORNER_B)
                   == ALL_TURNS) begin
        dec.sel = ORD_ADCB;
      end else begin
        dec.sel    = ORD_ABCD;
        dec.status = ST_NONE_FOUND;
      end
    end
  end

  assign push_valid = s3_valid;
  assign push_x     = s3_x;
  assign push_y     = s3_y;
  assign push_dec   = dec;

  `QVOF_ASSERT(front_hold_stalled, s3_valid && !push_ready |=> s3_valid, "stalled quad left the front end")
  `QVOF_ASSERT(front_permuted_sel, push_valid && push_dec.status == ST_PERMUTED |-> push_dec.sel != ORD_ABCD && push_dec.sel != ORD_DCBA, "permuted status without a permuted order")

endmodule

/* sv/qvof_back.sv */
// Back end: reorders the corners of a queued quad into the output register.
`include "quad_vertex_order_fix_macros.svh"

module qvof_back
  import qvof_pkg::*;
#(
  parameter int COORD_WIDTH
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    pop_valid,
  output logic                                    pop_ready,
  input  logic [NUM_CORNERS-1:0][COORD_WIDTH-1:0] pop_x,
  input  logic [NUM_CORNERS-1:0][COORD_WIDTH-1:0] pop_y,
  input  order_dec_t                              pop_dec,
  output logic                                    out_valid,
  input  logic                                    out_ready,
  output logic signed [COORD_WIDTH-1:0]           p0_x,
  output logic signed [COORD_WIDTH-1:0]           p0_y,
  output logic signed [COORD_WIDTH-1:0]           p1_x,
  output logic signed [COORD_WIDTH-1:0]           p1_y,
  output logic signed [COORD_WIDTH-1:0]           p2_x,
  output logic signed [COORD_WIDTH-1:0]           p2_y,
  output logic signed [COORD_WIDTH-1:0]           p3_x,
  output logic signed [COORD_WIDTH-1:0]           p3_y,
  output logic [1:0]                              order_status
);

  logic                                    load;
  logic                                    pop_fire;
  logic [NUM_CORNERS-1:0][COORD_WIDTH-1:0] ox;
  logic [NUM_CORNERS-1:0][COORD_WIDTH-1:0] oy;
  logic [1:0]                              ostat;

  // The output register takes a new beat whenever it is empty or being drained.
  assign load      = !out_valid || out_ready;
  assign pop_ready = load;
  assign pop_fire  = pop_valid && load;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= pop_valid;
    end
  end

  // Each output slot selects its corner by the chosen order.
  always_ff @(posedge clk) begin
    if (pop_fire) begin
      for (int s = 0; s < NUM_CORNERS; s++) begin
        ox[s] <= pop_x[order_corner(pop_dec.sel, 2'(s))];
        oy[s] <= pop_y[order_corner(pop_dec.sel, 2'(s))];
      end
      ostat <= pop_dec.status;
    end
  end

  assign p0_x         = ox[0];
  assign p0_y         = oy[0];
  assign p1_x         = ox[1];
  assign p1_y         = oy[1];
  assign p2_x         = ox[2];
  assign p2_y         = oy[2];
  assign p3_x         = ox[3];
  assign p3_y         = oy[3];
  assign order_status = ostat;

  `QVOF_ASSERT(back_pop_loads, pop_fire |=> out_valid, "popped quad did not reach the output")

endmodule

/* sv/quad_vertex_order_fix.sv */
// Top level of the quad vertex order fixer: front end, queue and back end.

// Puts the corners A, B, C, D of each quad into a consistent winding order
// and reports what it did in order_status (0 kept, 1 reversed to DCBA,
// 2 permuted, 3 no consistent order found, corners kept). One quad can be
// accepted every cycle unless stalled; the front end is a three-stage
// pipeline (edge vectors, cross products, signs and order choice) feeding
// a four-entry queue, and a registered back end reorders the corners. A
// quad passes the front stages, the queue and the output register in turn.
// The output register takes a new beat from the queue only when it is
// empty or being read, so a waiting result holds the queue, and the front
// pipeline stalls, along with the input, only once the queue is full.
module quad_vertex_order_fix
  import qvof_pkg::*;
#(
  parameter int COORD_WIDTH = 24
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [COORD_WIDTH-1:0] a_x,
  input  logic signed [COORD_WIDTH-1:0] a_y,
  input  logic signed [COORD_WIDTH-1:0] b_x,
  input  logic signed [COORD_WIDTH-1:0] b_y,
  input  logic signed [COORD_WIDTH-1:0] c_x,
  input  logic signed [COORD_WIDTH-1:0] c_y,
  input  logic signed [COORD_WIDTH-1:0] d_x,
  input  logic signed [COORD_WIDTH-1:0] d_y,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [COORD_WIDTH-1:0] p0_x,
  output logic signed [COORD_WIDTH-1:0] p0_y,
  output logic signed [COORD_WIDTH-1:0] p1_x,
  output logic signed [COORD_WIDTH-1:0] p1_y,
  output logic signed [COORD_WIDTH-1:0] p2_x,
  output logic signed [COORD_WIDTH-1:0] p2_y,
  output logic signed [COORD_WIDTH-1:0] p3_x,
  output logic signed [COORD_WIDTH-1:0] p3_y,
  output logic [1:0]                    order_status
);

  localparam int ENTRY_W = $bits(order_dec_t) + 2 * NUM_CORNERS * COORD_WIDTH;

  logic                                    push_valid;
  logic                                    push_ready;
  logic [NUM_CORNERS-1:0][COORD_WIDTH-1:0] push_x;
  logic [NUM_CORNERS-1:0][COORD_WIDTH-1:0] push_y;
  order_dec_t                              push_dec;
  logic                                    pop_valid;
  logic                                    pop_ready;
  logic [NUM_CORNERS-1:0][COORD_WIDTH-1:0] pop_x;
  logic [NUM_CORNERS-1:0][COORD_WIDTH-1:0] pop_y;
  order_dec_t                              pop_dec;
  logic [ENTRY_W-1:0]                      push_data;
  logic [ENTRY_W-1:0]                      pop_data;

  // Front end: accept and classify.
  qvof_front #(
    .COORD_WIDTH(COORD_WIDTH)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .a_x        (a_x),
    .a_y        (a_y),
    .b_x        (b_x),
    .b_y        (b_y),
    .c_x        (c_x),
    .c_y        (c_y),
    .d_x        (d_x),
    .d_y        (d_y),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_x     (push_x),
    .push_y     (push_y),
    .push_dec   (push_dec)
  );

  assign push_data = {push_dec, push_x, push_y};
  assign {pop_dec, pop_x, pop_y} = pop_data;

  // Queue between the two halves.
  qvof_fifo #(
    .WIDTH(ENTRY_W),
    .DEPTH(QUEUE_DEPTH)
  ) u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  // Back end: reorder and present the result.
  qvof_back #(
    .COORD_WIDTH(COORD_WIDTH)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .pop_valid    (pop_valid),
    .pop_ready    (pop_ready),
    .pop_x        (pop_x),
    .pop_y        (pop_y),
    .pop_dec      (pop_dec),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .p0_x         (p0_x),
    .p0_y         (p0_y),
    .p1_x         (p1_x),
    .p1_y         (p1_y),
    .p2_x         (p2_x),
    .p2_y         (p2_y),
    .p3_x         (p3_x),
    .p3_y         (p3_y),
    .order_status (order_status)
  );

endmodule
